// ===== rtl/rc4_stream_cipher_macros.svh =====
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Clocked property checks used by the RTL engine of the cipher.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// Check a property on every rising edge of clk_i, reset included
`define RC4_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

// Check a property on every rising edge of clk_i while rst_ni is released
`define RC4_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

// ===== rtl/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, codes and transfer structs of the RC4 stream cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  // Fixed widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PERM_AW    = 8;
  localparam int unsigned KEY_LEN_W  = 6;

  // Default key store depth and key length after reset
  localparam int unsigned         KEY_DEPTH_DEF = 32;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST  = 6'd16;

  // Last entry of the permutation
  localparam logic [PERM_AW-1:0] PERM_LAST = 8'hFF;

  // Item modes
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // Accepted input item
  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] data_byte;
  } rc4_cmd_t;

  // Result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] stream_byte;
    logic              not_keyed;
  } rc4_res_t;

  // Engine status toward the channel logic
  typedef struct packed {
    logic idle;
    logic res_valid;
  } rc4_stat_t;

endpackage

`default_nettype wire

// ===== rtl/rc4_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher
// Loads a key byte by byte, runs the key schedule and encrypts or decrypts
// data bytes with the keystream.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         in_valid_i/in_stall_o mode_i, key_byte_i, data_byte_i
//  result    out        out_valid_o/out_stall_i out_byte_o, stream_byte_o,
//                                               not_keyed_o
//  config    in         cfg_we_i              cfg_wdata_i (key_length)
//
//  A key byte is stored on transfer; a keyed data byte reads S[i], then S[j],
//  then S[S[i]+S[j]], with the swap written back over the single write port
//  of the permutation memory; before keying a data byte passes through.
//  The byte that completes the key starts the schedule, with in_stall_o high:
//  an identity fill of all 256 entries, then mixing by read, swap and write back.
//  Reset clears indices, key count and the keyed flag; key_length returns to 16.
//  A result waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher #(
  parameter int unsigned KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]   cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [rc4_pkg::BYTE_W-1:0]      key_byte_i,
  input  logic [rc4_pkg::BYTE_W-1:0]      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rc4_pkg::BYTE_W-1:0]      out_byte_o,
  output logic [rc4_pkg::BYTE_W-1:0]      stream_byte_o,
  output logic                            not_keyed_o
);

  import rc4_pkg::*;

  logic [KEY_LEN_W-1:0] key_length_q;
  logic                 out_valid_q, out_valid_d;
  rc4_res_t             out_q;
  rc4_cmd_t             cmd;
  logic                 cmd_valid;
  logic                 res_ready;
  logic                 res_take;
  rc4_stat_t            stat;
  rc4_res_t             res;

  // Take an input transfer only while the engine is idle
  assign in_stall_o = !stat.idle;
  assign cmd_valid  = in_valid_i && !in_stall_o;
  assign cmd        = '{mode: mode_i, key_byte: key_byte_i, data_byte: data_byte_i};

  // Output register frees up when empty or when its transfer completes
  assign res_ready = !out_valid_q || !out_stall_i;
  assign res_take  = stat.res_valid && res_ready;

  rc4_engine #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_length_i(key_length_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .res_ready_i (res_ready),
    .stat_o      (stat),
    .res_o       (res)
  );

  always_comb begin
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Key length register and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= KEY_LEN_RST;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_length_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded when the engine hands over a result
  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_q.out_byte;
  assign stream_byte_o = out_q.stream_byte;
  assign not_keyed_o   = out_q.not_keyed;

endmodule

`default_nettype wire

// ===== rtl/rc4_engine.sv =====
// ----------------------------------------------------------------------------
// RC4 engine
// Key store, permutation memory and the sequencer that runs the key
// schedule and the keystream generator by read, modify and write back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc4_stream_cipher_macros.svh"

module rc4_engine #(
  parameter int unsigned KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]    key_length_i,
  input  logic                             cmd_valid_i,
  input  rc4_pkg::rc4_cmd_t                cmd_i,
  input  logic                             res_ready_i,
  output rc4_pkg::rc4_stat_t               stat_o,
  output rc4_pkg::rc4_res_t                res_o
);

  import rc4_pkg::*;

  // Key count must hold KEY_DEPTH itself; the key index only the depth
  localparam int unsigned KCW = $clog2(KEY_DEPTH + 1);
  localparam int unsigned CW  = (KCW > KEY_LEN_W) ? KCW : KEY_LEN_W;
  localparam int unsigned KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_J,
    ST_MIX_WA,
    ST_MIX_WB,
    ST_GEN_J,
    ST_GEN_SWAP,
    ST_GEN_KS
  } state_e;

  state_e              state_q, state_d;
  logic [PERM_AW-1:0]  i_q, i_d;
  logic [PERM_AW-1:0]  j_q, j_d;
  logic [PERM_AW-1:0]  n_q, n_d;
  logic [KAW-1:0]      kidx_q, kidx_d;
  logic [CW-1:0]       key_cnt_q, key_cnt_d;
  logic [CW-1:0]       len_q, len_d;
  logic                keyed_q, keyed_d;

  logic [BYTE_W-1:0]   si_q, si_d;
  logic [BYTE_W-1:0]   sj_q, sj_d;
  logic [PERM_AW-1:0]  t_q, t_d;
  logic [BYTE_W-1:0]   data_q, data_d;

  logic [CW-1:0]       len_ext;
  logic [CW-1:0]       eff_len;
  logic [CW-1:0]       key_cnt_inc;
  logic [PERM_AW-1:0]  mix_j;
  logic [BYTE_W-1:0]   ks;

  // Permutation memory ports
  logic [BYTE_W-1:0]   perm_mem [2**PERM_AW];
  logic                perm_we;
  logic [PERM_AW-1:0]  perm_waddr;
  logic [BYTE_W-1:0]   perm_wdata;
  logic [PERM_AW-1:0]  perm_raddr;
  logic [BYTE_W-1:0]   perm_rdata_q;

  // Key store ports
  logic [BYTE_W-1:0]   key_mem [KEY_DEPTH];
  logic                key_we;
  logic [BYTE_W-1:0]   key_rdata_q;

  logic                res_valid;
  rc4_res_t            res;

  // Clamp the configured key length to 1 .. KEY_DEPTH
  assign len_ext = CW'(key_length_i);
  always_comb begin
    if (len_ext == '0) begin
      eff_len = CW'(1);
    end else if (len_ext > CW'(KEY_DEPTH)) begin
      eff_len = CW'(KEY_DEPTH);
    end else begin
      eff_len = len_ext;
    end
  end

  assign key_cnt_inc = key_cnt_q + CW'(1);
  assign mix_j       = j_q + perm_rdata_q + key_rdata_q;

  // Keystream byte: forward the two swap writes, which the read may miss
  always_comb begin
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = perm_rdata_q;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    n_d        = n_q;
    kidx_d     = kidx_q;
    key_cnt_d  = key_cnt_q;
    len_d      = len_q;
    keyed_d    = keyed_q;
    si_d       = si_q;
    sj_d       = sj_q;
    t_d        = t_q;
    data_d     = data_q;
    perm_we    = 1'b0;
    perm_waddr = n_q;
    perm_wdata = n_q;
    perm_raddr = t_q;
    key_we     = 1'b0;
    res_valid  = 1'b0;
    res        = '{out_byte: data_q, stream_byte: '0, not_keyed: 1'b1};

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          data_d = cmd_i.data_byte;
          if (cmd_i.mode == MODE_KEY) begin
            // Store the key byte; start the schedule once the key is complete
            key_we = 1'b1;
            if (key_cnt_inc >= eff_len) begin
              key_cnt_d = '0;
              len_d     = eff_len;
              n_d       = '0;
              state_d   = ST_FILL;
            end else begin
              key_cnt_d = key_cnt_inc;
            end
          end else if (keyed_q) begin
            // Advance i and fetch S[i]
            i_d        = i_q + PERM_AW'(1);
            perm_raddr = i_q + PERM_AW'(1);
            state_d    = ST_GEN_J;
          end else begin
            state_d = ST_PASS;
          end
        end
      end

      ST_PASS: begin
        res_valid = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      ST_FILL: begin
        // Write the identity, one entry a cycle
        perm_we = 1'b1;
        n_d     = n_q + PERM_AW'(1);
        if (n_q == PERM_LAST) begin
          j_d     = '0;
          kidx_d  = '0;
          state_d = ST_MIX_RD;
        end
      end

      ST_MIX_RD: begin
        perm_raddr = n_q;
        state_d    = ST_MIX_J;
      end

      ST_MIX_J: begin
        // S[n] and the key byte are back; fetch S[j]
        si_d       = perm_rdata_q;
        j_d        = mix_j;
        perm_raddr = mix_j;
        if (CW'(kidx_q) == len_q - CW'(1)) begin
          kidx_d = '0;
        end else begin
          kidx_d = kidx_q + KAW'(1);
        end
        state_d = ST_MIX_WA;
      end

      ST_MIX_WA: begin
        perm_we    = 1'b1;
        perm_waddr = n_q;
        perm_wdata = perm_rdata_q;
        state_d    = ST_MIX_WB;
      end

      ST_MIX_WB: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = si_q;
        n_d        = n_q + PERM_AW'(1);
        if (n_q == PERM_LAST) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MIX_RD;
        end
      end

      ST_GEN_J: begin
        // S[i] is back; advance j and fetch S[j]
        si_d       = perm_rdata_q;
        j_d        = j_q + perm_rdata_q;
        perm_raddr = j_q + perm_rdata_q;
        state_d    = ST_GEN_SWAP;
      end

      ST_GEN_SWAP: begin
        // S[j] is back; write it to S[i] and fetch S[S[i] + S[j]]
        sj_d       = perm_rdata_q;
        perm_we    = 1'b1;
        perm_waddr = i_q;
        perm_wdata = perm_rdata_q;
        t_d        = si_q + perm_rdata_q;
        perm_raddr = si_q + perm_rdata_q;
        state_d    = ST_GEN_KS;
      end

      ST_GEN_KS: begin
        // Finish the swap and hold the result until the output takes it
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = si_q;
        res_valid  = 1'b1;
        res        = '{out_byte: data_q ^ ks, stream_byte: ks, not_keyed: 1'b0};
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      j_q       <= '0;
      n_q       <= '0;
      kidx_q    <= '0;
      key_cnt_q <= '0;
      len_q     <= CW'(1);
      keyed_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      j_q       <= j_d;
      n_q       <= n_d;
      kidx_q    <= kidx_d;
      key_cnt_q <= key_cnt_d;
      len_q     <= len_d;
      keyed_q   <= keyed_d;
    end
  end

  // Working bytes
  always_ff @(posedge clk_i) begin
    si_q   <= si_d;
    sj_q   <= sj_d;
    t_q    <= t_d;
    data_q <= data_d;
  end

  // Permutation memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata_q <= perm_mem[perm_raddr];
  end

  // Key store, written by key transfers and read by the schedule
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_cnt_q[KAW-1:0]] <= cmd_i.key_byte;
    end
    key_rdata_q <= key_mem[kidx_q];
  end

  assign stat_o = '{idle: (state_q == ST_IDLE), res_valid: res_valid};
  assign res_o  = res;

  `RC4_ASSERT(a_cmd_only_idle, cmd_valid_i |-> (state_q == ST_IDLE), "command while engine busy")
  `RC4_ASSERT(a_gen_latency, (cmd_valid_i && (cmd_i.mode == MODE_DATA) && keyed_q) |=> ##2 res_valid, "late keystream result")
  `RC4_ASSERT(a_key_cnt_range, key_cnt_q < CW'(KEY_DEPTH), "key count beyond key store")
  `RC4_ASSERT(a_keyed_sticky, !$fell(keyed_q), "keyed flag dropped")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 stream cipher testbench
// Feeds key and data bytes through the valid/stall input channel and checks
// every result against a cycle-free model of the cipher kept in the bench.
// A short directed part covers pass-through before keying, length clamping,
// a length change in the middle of key loading and rekeying. Random phases
// follow, each at a new key length, with random gaps on both channels.
// ----------------------------------------------------------------------------

module tb;
  import rc4_pkg::*;

  localparam int unsigned KEY_DEPTH      = KEY_DEPTH_DEF;
  localparam int unsigned ITEMS_TARGET   = 1300;
  // Key schedule runs with no result; wait that out before a write
  localparam int unsigned SETTLE_CYCLES  = 1300;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned REPORT_MAX     = 10;

  // DUT ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [KEY_LEN_W-1:0] cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i      = MODE_KEY;
  logic [BYTE_W-1:0]    key_byte_i  = '0;
  logic [BYTE_W-1:0]    data_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [BYTE_W-1:0]    out_byte_o;
  logic [BYTE_W-1:0]    stream_byte_o;
  logic                 not_keyed_o;

  // Cipher model state
  logic [BYTE_W-1:0]    sbox [256];
  logic [BYTE_W-1:0]    key_mem [KEY_DEPTH];
  int unsigned          key_fill = 0;
  logic [PERM_AW-1:0]   ks_i = '0;
  logic [PERM_AW-1:0]   ks_j = '0;
  logic                 is_keyed = 1'b0;
  logic [KEY_LEN_W-1:0] key_len_reg = KEY_LEN_RST;

  // Stimulus and result bookkeeping
  rc4_cmd_t    cmd_backlog [$];
  rc4_res_t    results_due [$];
  int unsigned items_sent   = 0;
  int unsigned items_taken  = 0;
  int unsigned err_count    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_wait    = 0;
  int unsigned stall_left   = 0;
  logic        in_taken     = 1'b0;
  logic        send_idle_on = 1'b1;
  logic        recv_idle_on = 1'b1;

  // Generator-side mirror of the key fill, to build complete keys
  int unsigned gen_fill = 0;
  int unsigned gen_span = 16;

  rc4_stream_cipher #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .key_byte_i   (key_byte_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .stream_byte_o(stream_byte_o),
    .not_keyed_o  (not_keyed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp a key length setting to the range the schedule uses
  function automatic int unsigned clamp_span(logic [KEY_LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > KEY_DEPTH) return KEY_DEPTH;
    return 32'(len);
  endfunction

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned pick_gap(logic on);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!on || roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Identity fill, then mix with the repeated key
  task automatic run_key_schedule(int unsigned span);
    logic [BYTE_W-1:0] j;
    logic [BYTE_W-1:0] t;
    j = '0;
    for (int n = 0; n < 256; n++) sbox[n] = n[BYTE_W-1:0];
    for (int n = 0; n < 256; n++) begin
      j = j + sbox[n] + key_mem[n % span];
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    ks_i = '0;
    ks_j = '0;
    is_keyed = 1'b1;
  endtask

  // Advance the model by one accepted transfer and queue its result, if any
  task automatic cipher_step(rc4_cmd_t c);
    int unsigned       span;
    logic [BYTE_W-1:0] si;
    logic [BYTE_W-1:0] sj;
    logic [BYTE_W-1:0] pos;
    rc4_res_t          r;
    if (c.mode == MODE_KEY) begin
      span = clamp_span(key_len_reg);
      if (key_fill < KEY_DEPTH) key_mem[key_fill] = c.key_byte;
      key_fill++;
      if (key_fill >= span) begin
        run_key_schedule(span);
        key_fill = 0;
      end
    end else if (!is_keyed) begin
      r.out_byte    = c.data_byte;
      r.stream_byte = '0;
      r.not_keyed   = 1'b1;
      results_due.push_back(r);
    end else begin
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + sbox[ks_i];
      si = sbox[ks_i];
      sj = sbox[ks_j];
      sbox[ks_i] = sj;
      sbox[ks_j] = si;
      pos = si + sj;
      r.stream_byte = sbox[pos];
      r.out_byte    = c.data_byte ^ sbox[pos];
      r.not_keyed   = 1'b0;
      results_due.push_back(r);
    end
  endtask

  task automatic push_item(logic mode, logic [BYTE_W-1:0] kb, logic [BYTE_W-1:0] db);
    rc4_cmd_t c;
    c.mode      = mode;
    c.key_byte  = kb;
    c.data_byte = db;
    cmd_backlog.push_back(c);
    items_sent++;
    if (mode == MODE_KEY) begin
      gen_fill++;
      if (gen_fill >= gen_span) gen_fill = 0;
    end
  endtask

  task automatic push_data(int unsigned count);
    repeat (count) push_item(MODE_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic push_keys(int unsigned count);
    repeat (count) push_item(MODE_KEY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Write the key length; only called with the block idle
  task automatic set_key_length(logic [KEY_LEN_W-1:0] len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    key_len_reg = len;
    gen_span    = clamp_span(len);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hold off until every transfer is in and every result is out
  task automatic drain_and_settle();
    @(negedge clk_i);
    while (items_taken != items_sent || results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Input driver: present the next pending item once the last one transferred
  always @(negedge clk_i) begin : drive
    rc4_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (send_wait != 0) begin
        send_wait  <= send_wait - 1;
        in_valid_i <= 1'b0;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        in_valid_i  <= 1'b1;
        mode_i      <= nxt.mode;
        key_byte_i  <= nxt.key_byte;
        data_byte_i <= nxt.data_byte;
        send_wait   <= pick_gap(send_idle_on);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: random stall runs
  always @(negedge clk_i) begin : backpressure
    int unsigned n;
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      n = pick_gap(recv_idle_on);
      out_stall_i <= (n != 0);
      stall_left  <= (n != 0) ? n - 1 : 0;
    end
  end

  // Monitor: check results first, then predict from the accepted input
  always @(posedge clk_i) begin : watch
    rc4_cmd_t c;
    rc4_res_t got;
    rc4_res_t want;
    logic     in_fire;
    logic     out_fire;
    in_fire  = rst_ni && in_valid_i && !in_stall_o;
    out_fire = rst_ni && out_valid_o && !out_stall_i;
    in_taken <= in_fire;

    if (out_fire) begin
      got.out_byte    = out_byte_o;
      got.stream_byte = stream_byte_o;
      got.not_keyed   = not_keyed_o;
      if (results_due.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX)
          $display("unexpected result: out=%02h ks=%02h nk=%0b",
                   got.out_byte, got.stream_byte, got.not_keyed);
      end else begin
        want = results_due.pop_front();
        if (got.out_byte !== want.out_byte || got.stream_byte !== want.stream_byte ||
            got.not_keyed !== want.not_keyed) begin
          err_count++;
          if (err_count <= REPORT_MAX)
            $display({"mismatch: expected out=%02h ks=%02h nk=%0b,",
                      " got out=%02h ks=%02h nk=%0b"},
                     want.out_byte, want.stream_byte, want.not_keyed,
                     got.out_byte, got.stream_byte, got.not_keyed);
        end
      end
    end

    if (in_fire) begin
      c.mode      = mode_i;
      c.key_byte  = key_byte_i;
      c.data_byte = data_byte_i;
      cipher_step(c);
      items_taken++;
    end

    // Watchdog on cycles with no transfer on either channel
    if (rst_ni) begin
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", quiet_cycles);
        $display("[rc4_stream_cipher] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned          roll;
    int unsigned          need;
    logic [KEY_LEN_W-1:0] len;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Data before any key passes through; a partial key does not key the block
    push_item(MODE_DATA, 8'h00, 8'h00);
    push_item(MODE_DATA, 8'hFF, 8'hFF);
    push_item(MODE_KEY,  8'h00, 8'hFF);
    push_item(MODE_KEY,  8'hFF, 8'h00);
    push_item(MODE_KEY,  8'h5A, 8'hA5);
    push_item(MODE_DATA, 8'h00, 8'h3C);
    drain_and_settle();

    // Length 0 is used as 1, set with three bytes already loaded
    set_key_length('0);
    push_item(MODE_KEY,  8'h80, 8'h00);
    push_item(MODE_DATA, 8'h00, 8'hFF);
    push_item(MODE_DATA, 8'hFF, 8'h00);
    push_item(MODE_DATA, 8'h00, 8'h11);
    push_item(MODE_DATA, 8'h00, 8'hEE);
    drain_and_settle();

    // Rekey while in use: old keystream continues until the new key completes
    set_key_length(6'd2);
    push_item(MODE_KEY,  8'hFF, 8'h00);
    push_item(MODE_KEY,  8'h01, 8'h00);
    push_data(3);
    push_item(MODE_KEY,  8'h77, 8'h00);
    push_item(MODE_DATA, 8'h00, 8'h55);
    push_item(MODE_KEY,  8'h88, 8'h00);
    push_item(MODE_DATA, 8'h00, 8'hFF);
    drain_and_settle();

    // Random phases, each at a new key length
    while (items_sent < ITEMS_TARGET) begin
      roll = $urandom_range(0, 9);
      case (roll)
        0:       len = '0;
        1:       len = 6'd1;
        2:       len = 6'($urandom_range(2, 8));
        3:       len = 6'd16;
        4:       len = 6'd32;
        5:       len = 6'($urandom_range(33, 62));
        6:       len = 6'd63;
        default: len = 6'($urandom_range(0, 63));
      endcase
      set_key_length(len);
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);

      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) < 8) begin
          // Complete the key, then a run of data
          need = (gen_fill < gen_span) ? gen_span - gen_fill : 1;
          push_keys(need);
          push_data($urandom_range(4, 60));
        end else begin
          // Noise: key and data bytes mixed, keys often left unfinished
          repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 1) != 0) push_keys(1);
            else push_data(1);
          end
        end
      end
      drain_and_settle();
    end

    repeat (50) @(negedge clk_i);
    if (err_count == 0 && results_due.size() == 0) begin
      $display("[rc4_stream_cipher] OK");
    end else begin
      $display("[rc4_stream_cipher] ERROR");
    end
    $finish;
  end

endmodule
